@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the console renderer modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked at every rising edge, disabled while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked at every rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ sv/tcgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tcgr_pkg
// Types, constants and helper functions of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int MAX_GLYPHS       = 256;
  localparam int MAX_GLYPH_HEIGHT = 32;
  localparam int MAX_GLYPH_WIDTH  = 16;
  localparam int CELL_SPACING     = 1;

  localparam int STORE_DEPTH = MAX_GLYPHS * MAX_GLYPH_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int GLYPH_W     = $clog2(MAX_GLYPHS);
  localparam int ROW_W       = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;

  // Job queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Commands and result kinds.
  localparam logic CMD_PUT     = 1'b0;
  localparam logic CMD_LOAD    = 1'b1;
  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Control characters.
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_ASCII_END = 8'd128;
  localparam int         TAB_STEP = 4;

  // Configuration register indexes.
  localparam logic [2:0] CFG_FG_COLOR     = 3'd0;
  localparam logic [2:0] CFG_BG_COLOR     = 3'd1;
  localparam logic [2:0] CFG_GLYPH_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_GLYPH_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_GLYPH_COUNT  = 3'd4;
  localparam logic [2:0] CFG_TEXT_COLUMNS = 3'd5;
  localparam logic [2:0] CFG_TEXT_ROWS    = 3'd6;

  typedef struct packed {
    logic        command;
    logic [7:0]  char_code;
    logic [4:0]  font_row;
    logic [15:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] pixel_bits;
    logic [4:0]  pixel_count;
    logic [31:0] draw_fg;
    logic [31:0] draw_bg;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic [4:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [8:0]  glyph_count;
    logic [7:0]  text_columns;
    logic [6:0]  text_rows;
  } cfg_t;

  // One unit of work for the back: a glyph row write, or a character
  // draw that may be followed by a scroll, or a lone scroll.
  typedef struct packed {
    logic               is_load;
    logic               draw;
    logic               scroll;
    logic [GLYPH_W-1:0] glyph;
    logic [ROW_W-1:0]   frow;
    logic [11:0]        px;
    logic [11:0]        py_base;
    logic [15:0]        bits;
  } job_t;

  function automatic logic [4:0] clamp_width(input logic [4:0] v);
    if (v == 5'd0) return 5'd1;
    if (v > 5'(MAX_GLYPH_WIDTH)) return 5'(MAX_GLYPH_WIDTH);
    return v;
  endfunction

  function automatic logic [5:0] clamp_height(input logic [5:0] v);
    if (v == 6'd0) return 6'd1;
    if (v > 6'(MAX_GLYPH_HEIGHT)) return 6'(MAX_GLYPH_HEIGHT);
    return v;
  endfunction

  function automatic logic [4:0] cell_width(input logic [4:0] gw);
    return clamp_width(gw) + 5'(CELL_SPACING);
  endfunction

  // Pixels written per row: the cell width, but no more than whole glyph bytes.
  function automatic logic [4:0] pixel_cnt(input logic [4:0] gw);
    logic [5:0] w;
    logic [5:0] bytes8;
    logic [5:0] cellw;
    w      = {1'b0, clamp_width(gw)};
    cellw  = w + 6'(CELL_SPACING);
    bytes8 = ((w + 6'd7) >> 3) << 3;
    return (cellw < bytes8) ? 5'(cellw) : 5'(bytes8);
  endfunction

  function automatic logic [15:0] pixel_mask(input logic [4:0] cnt);
    if (cnt >= 5'd16) return 16'hFFFF;
    return 16'hFFFF << (5'd16 - cnt);
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [GLYPH_W-1:0] g,
                                                   input logic [ROW_W-1:0] y);
    return ADDR_W'(ADDR_W'(g) * ADDR_W'(MAX_GLYPH_HEIGHT) + ADDR_W'(y));
  endfunction

endpackage

@@ sv/tcgr_ram.sv @@
// ----------------------------------------------------------------------------
// tcgr_ram
// Generic single write port, single read port RAM with registered read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module tcgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

@@ sv/tcgr_front.sv @@
// ----------------------------------------------------------------------------
// tcgr_front
// Accepts items, tracks the text cursor and turns each item into a job for
// the back: glyph row writes, character draws and scrolls.
// ----------------------------------------------------------------------------
module tcgr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  tcgr_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcgr_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output tcgr_pkg::job_t     q_job
);

  import tcgr_pkg::*;

  logic [7:0]  cur_col_r, cur_col_nxt;
  logic [6:0]  cur_row_r, cur_row_nxt;

  logic        accept;
  logic [7:0]  cols;
  logic [6:0]  rows;
  logic [8:0]  cx;
  logic [7:0]  cy;
  logic [7:0]  dcol;
  logic [7:0]  dcode;
  logic [7:0]  gsel;
  logic        draw;
  logic        scroll;
  logic        load_ok;
  logic [12:0] px_full;
  logic [12:0] py_full;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign cols = (cfg.text_columns == 8'd0) ? 8'd1 : cfg.text_columns;
  assign rows = (cfg.text_rows == 7'd0) ? 7'd1 : cfg.text_rows;

  always_comb begin
    cx     = {1'b0, cur_col_r};
    cy     = {1'b0, cur_row_r};
    dcol   = cur_col_r;
    dcode  = in_item.char_code;
    draw   = 1'b0;
    scroll = 1'b0;
    case (in_item.char_code)
      CH_NL: begin
        cy = {1'b0, cur_row_r} + 8'd1;
        cx = 9'd0;
      end
      CH_BS: begin
        if (cur_col_r != 8'd0) begin
          cx    = {1'b0, cur_col_r} - 9'd1;
          dcol  = cur_col_r - 8'd1;
          dcode = CH_SPACE;
          draw  = 1'b1;
        end
      end
      CH_TAB: begin
        cx = ({1'b0, cur_col_r} + 9'(TAB_STEP)) & ~9'(TAB_STEP - 1);
      end
      default: begin
        cx   = {1'b0, cur_col_r} + 9'd1;
        draw = 1'b1;
      end
    endcase
    if (cx >= {1'b0, cols}) begin
      cx = 9'd0;
      cy = cy + 8'd1;
    end
    // Only one scroll per item, even if the cursor sits far past the bottom.
    if (cy >= {1'b0, rows}) begin
      scroll = 1'b1;
      cy     = cy - 8'd1;
      cx     = 9'd0;
    end
  end

  // Code 0, codes of 128 and above, and codes at or past the configured glyph count fall back to glyph 0.
  always_comb begin
    if ((dcode != 8'd0) && (dcode < CH_ASCII_END) && ({1'b0, dcode} < cfg.glyph_count) &&
        (9'(dcode) < 9'(MAX_GLYPHS))) begin
      gsel = dcode;
    end else begin
      gsel = 8'd0;
    end
  end

  assign px_full = 13'(dcol) * 13'(cell_width(cfg.glyph_width));
  assign py_full = 13'(cur_row_r) * 13'(clamp_height(cfg.glyph_height));

  assign load_ok = (9'(in_item.char_code) < 9'(MAX_GLYPHS)) &&
                   (6'(in_item.font_row) < 6'(MAX_GLYPH_HEIGHT));

  always_comb begin
    q_job = '0;
    if (in_item.command == CMD_LOAD) begin
      q_job.is_load = 1'b1;
      q_job.glyph   = GLYPH_W'(in_item.char_code);
      q_job.frow    = ROW_W'(in_item.font_row);
      q_job.bits    = in_item.row_bits;
    end else begin
      q_job.draw    = draw;
      q_job.scroll  = scroll;
      q_job.glyph   = GLYPH_W'(gsel);
      q_job.px      = px_full[11:0];
      q_job.py_base = py_full[11:0];
    end
  end

  assign q_push = accept && ((in_item.command == CMD_LOAD) ? load_ok : (draw || scroll));

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (accept && (in_item.command == CMD_PUT)) begin
      cur_col_nxt = cx[7:0];
      cur_row_nxt = cy[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

endmodule

@@ sv/tcgr_fifo.sv @@
// ----------------------------------------------------------------------------
// tcgr_fifo
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcgr_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tcgr_pkg::job_t push_job,
  input  logic           pop,
  output tcgr_pkg::job_t head_job,
  output logic           empty,
  output logic           full
);

  import tcgr_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `ASSERT_RST(a_fifo_no_overflow, clk, rst_n, full |-> !(push && !pop), "job pushed into a full queue")
  `ASSERT_RST(a_fifo_no_underflow, clk, rst_n, empty |-> !pop, "job popped from an empty queue")
  `ASSERT_RST(a_fifo_ptr_gap, clk, rst_n, (cnt_r != QCNT_W'(QDEPTH)) |-> (QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(cnt_r)), "queue pointers disagree with the fill count")

endmodule

@@ sv/tcgr_back.sv @@
// ----------------------------------------------------------------------------
// tcgr_back
// Executes jobs: writes glyph rows, reads one glyph scanline per cycle from the
// glyph RAM unless results back up, and forms draw and scroll results through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcgr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tcgr_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  tcgr_pkg::job_t      q_job,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output tcgr_pkg::out_item_t out_item
);

  import tcgr_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DRAW   = 2'd1;
  localparam logic [1:0] PH_SCROLL = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  job_t             job_r, job_nxt;
  logic [ROW_W-1:0] y_r, y_nxt;

  // Stage after the RAM read: metadata aligned with the read data.
  logic             s1_v_r, s1_v_nxt;
  logic             s1_kind_r, s1_kind_nxt;
  logic [11:0]      s1_px_r, s1_px_nxt;
  logic [11:0]      s1_py_r, s1_py_nxt;
  logic             s1_last_r, s1_last_nxt;

  logic             out_v_r, out_v_nxt;
  out_item_t        out_r, out_nxt;

  logic [5:0]       h;
  logic [4:0]       cnt;
  logic             y_last;
  logic             last_entry;
  logic             s1_pop;
  logic             can_issue;
  logic             issue;
  logic             ram_we;
  logic             ram_re;
  logic [15:0]      ram_rdata;

  assign h      = clamp_height(cfg.glyph_height);
  assign cnt    = pixel_cnt(cfg.glyph_width);
  assign y_last = (6'(y_r) == h - 6'd1);

  assign last_entry = (phase_r == PH_SCROLL) ||
                      ((phase_r == PH_DRAW) && y_last && !job_r.scroll);

  assign s1_pop    = s1_v_r && (!out_v_r || out_ready);
  assign can_issue = !s1_v_r || s1_pop;
  assign issue     = (phase_r != PH_IDLE) && can_issue;

  // The next job is taken while idle, or as the current one issues its final entry.
  assign q_pop  = ((phase_r == PH_IDLE) || (issue && last_entry)) && !q_empty;
  assign ram_we = q_pop && q_job.is_load;
  assign ram_re = issue && (phase_r == PH_DRAW);

  tcgr_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_glyph_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (store_addr(q_job.glyph, q_job.frow)),
    .wdata (q_job.bits),
    .re    (ram_re),
    .raddr (store_addr(job_r.glyph, y_r)),
    .rdata (ram_rdata)
  );

  always_comb begin
    phase_nxt = phase_r;
    job_nxt   = job_r;
    y_nxt     = y_r;
    if (issue) begin
      case (phase_r)
        PH_DRAW: begin
          if (y_last) begin
            phase_nxt = job_r.scroll ? PH_SCROLL : PH_IDLE;
          end else begin
            y_nxt = y_r + 1'b1;
          end
        end
        PH_SCROLL: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (q_pop && !q_job.is_load) begin
      job_nxt   = q_job;
      y_nxt     = '0;
      phase_nxt = q_job.draw ? PH_DRAW : PH_SCROLL;
    end
  end

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_kind_nxt = s1_kind_r;
    s1_px_nxt   = s1_px_r;
    s1_py_nxt   = s1_py_r;
    s1_last_nxt = s1_last_r;
    if (issue) begin
      s1_v_nxt    = 1'b1;
      s1_kind_nxt = (phase_r == PH_SCROLL) ? KIND_SCROLL : KIND_DRAW;
      s1_px_nxt   = job_r.px;
      s1_py_nxt   = job_r.py_base + 12'(y_r);
      s1_last_nxt = last_entry;
    end else if (s1_pop) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (s1_pop) begin
      out_v_nxt           = 1'b1;
      out_nxt.kind        = s1_kind_r;
      out_nxt.draw_fg     = cfg.fg_color;
      out_nxt.draw_bg     = cfg.bg_color;
      out_nxt.last        = s1_last_r;
      if (s1_kind_r == KIND_SCROLL) begin
        out_nxt.pixel_x     = '0;
        out_nxt.pixel_y     = '0;
        out_nxt.pixel_bits  = '0;
        out_nxt.pixel_count = '0;
      end else begin
        out_nxt.pixel_x     = s1_px_r;
        out_nxt.pixel_y     = s1_py_r;
        out_nxt.pixel_bits  = ram_rdata & pixel_mask(cnt);
        out_nxt.pixel_count = cnt;
      end
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    s1_kind_r <= s1_kind_nxt;
    s1_px_r   <= s1_px_nxt;
    s1_py_r   <= s1_py_nxt;
    s1_last_r <= s1_last_nxt;
    out_r     <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      y_r     <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      y_r     <= y_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  `ASSERT_RST(a_back_hold_when_blocked, clk, rst_n, (s1_v_r && out_v_r && !out_ready) |-> !issue, "scanline issued while the result path is blocked")
  `ASSERT_RST(a_back_row_in_range, clk, rst_n, (phase_r == PH_DRAW) |-> (6'(y_r) < h), "scanline counter beyond glyph height")
  `ASSERT_RST(a_back_load_stays_idle, clk, rst_n, (phase_r == PH_IDLE && q_pop && q_job.is_load) |=> (phase_r == PH_IDLE), "glyph row write started a draw")
  `ASSERT_RST(a_back_no_pop_midjob, clk, rst_n, (phase_r != PH_IDLE && !issue) |-> !q_pop, "job taken while the current one is unfinished")

endmodule

@@ sv/text_console_glyph_renderer_core.sv @@
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core
// Text console engine: cursor handling, glyph store and scanline results.
// ----------------------------------------------------------------------------
// A put-character item gives one draw result per glyph scanline of a drawn
// character, plus a scroll result when it also causes a scroll; an item
// that only scrolls gives the scroll result alone, and a font row load is
// written into the glyph RAM on the back side with no result. The single
// read port of the glyph RAM yields one scanline per cycle while the result
// path is not blocked. A four-entry job queue sits between the input side and
// the glyph RAM side, so items keep being accepted while earlier characters
// are still being drawn or their results wait to be taken. The glyph store
// is not cleared after reset: every glyph row must be loaded before a
// character that uses it is drawn.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcgr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output tcgr_pkg::out_item_t out_item
);

  import tcgr_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_push;
  logic q_pop;
  logic q_empty;
  logic q_full;
  job_t push_job;
  job_t head_job;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FG_COLOR:     cfg_nxt.fg_color     = cfg_wdata;
        CFG_BG_COLOR:     cfg_nxt.bg_color     = cfg_wdata;
        CFG_GLYPH_WIDTH:  cfg_nxt.glyph_width  = cfg_wdata[4:0];
        CFG_GLYPH_HEIGHT: cfg_nxt.glyph_height = cfg_wdata[5:0];
        CFG_GLYPH_COUNT:  cfg_nxt.glyph_count  = cfg_wdata[8:0];
        CFG_TEXT_COLUMNS: cfg_nxt.text_columns = cfg_wdata[7:0];
        CFG_TEXT_ROWS:    cfg_nxt.text_rows    = cfg_wdata[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_color     <= 32'h00FF_FFFF;
      cfg_r.bg_color     <= 32'h0;
      cfg_r.glyph_width  <= 5'd8;
      cfg_r.glyph_height <= 6'd16;
      cfg_r.glyph_count  <= 9'd256;
      cfg_r.text_columns <= 8'd80;
      cfg_r.text_rows    <= 7'd30;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcgr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  tcgr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  tcgr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_job     (head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

@@ bench/glyph_scanline_checker.sv @@
// ----------------------------------------------------------------------------
// glyph_scanline_checker
// Watches the configuration port and both item channels of the text console
// renderer. It keeps its own cursor, register set and glyph store, predicts
// the scanline and scroll results of every accepted item, and compares each
// accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_scanline_checker
  import tcgr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatches,
  output int        scanlines_outstanding,
  output int        rows_seen,
  output int        scrolls_seen
);

  logic [31:0] fg_reg;
  logic [31:0] bg_reg;
  logic [4:0]  width_reg;
  logic [5:0]  height_reg;
  logic [8:0]  count_reg;
  logic [7:0]  cols_reg;
  logic [6:0]  rows_reg;
  logic [7:0]  col_pos;
  logic [6:0]  row_pos;
  logic [15:0] glyph_rows [STORE_DEPTH];

  out_item_t scanlines_due [$];
  out_item_t step_rows [$];
  out_item_t want;

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  task automatic push_row(input logic kind, input logic [11:0] px, input logic [11:0] py,
                          input logic [15:0] bits, input logic [4:0] cnt);
    out_item_t r;
    r             = '0;
    r.kind        = kind;
    r.pixel_x     = px;
    r.pixel_y     = py;
    r.pixel_bits  = bits;
    r.pixel_count = cnt;
    r.draw_fg     = fg_reg;
    r.draw_bg     = bg_reg;
    step_rows.push_back(r);
  endtask

  // One draw result per glyph scanline of the character at (col, row).
  task automatic render_glyph_rows(input int unsigned code, input int unsigned col,
                                   input int unsigned row);
    int unsigned gc, g, w, h, cellw, bytes8, cnt, px, y;
    logic [15:0] mask;
    gc = (count_reg > MAX_GLYPHS) ? MAX_GLYPHS : count_reg;
    g = (code > 0 && code < CH_ASCII_END && code < gc) ? code : 0;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_GLYPH_WIDTH) ? MAX_GLYPH_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 :
        ((height_reg > MAX_GLYPH_HEIGHT) ? MAX_GLYPH_HEIGHT : height_reg);
    cellw = w + CELL_SPACING;
    bytes8 = ((w + 7) / 8) * 8;
    cnt = (cellw < bytes8) ? cellw : bytes8;
    mask = (cnt >= 16) ? 16'hFFFF : (16'hFFFF << (16 - cnt));
    px = col * cellw;
    for (y = 0; y < h; y++) begin
      push_row(KIND_DRAW, px[11:0], 12'(row * h + y),
               glyph_rows[g * MAX_GLYPH_HEIGHT + y] & mask, cnt[4:0]);
    end
  endtask

  task automatic predict_console_step(input in_item_t it);
    int unsigned cx, cy, cols, rows;
    out_item_t r;
    if (it.command == CMD_LOAD) begin
      glyph_rows[int'(it.char_code) * MAX_GLYPH_HEIGHT + int'(it.font_row)] = it.row_bits;
      return;
    end
    cx = col_pos;
    cy = row_pos;
    cols = (cols_reg == 0) ? 1 : cols_reg;
    rows = (rows_reg == 0) ? 1 : rows_reg;
    step_rows.delete();
    case (it.char_code)
      CH_NL: begin
        cy++;
        cx = 0;
      end
      CH_BS: begin
        // Nothing is drawn at column zero.
        if (cx != 0) begin
          cx--;
          render_glyph_rows(CH_SPACE, cx, cy);
        end
      end
      CH_TAB: cx = (cx + TAB_STEP) & ~(TAB_STEP - 1);
      default: begin
        render_glyph_rows(it.char_code, cx, cy);
        cx++;
      end
    endcase
    if (cx >= cols) begin
      cx = 0;
      cy++;
    end
    if (cy >= rows) begin
      push_row(KIND_SCROLL, '0, '0, '0, '0);
      cy = cy - 1;
      cx = 0;
    end
    col_pos = cx[7:0];
    row_pos = cy[6:0];
    if (step_rows.size() > 0) begin
      r = step_rows[step_rows.size() - 1];
      r.last = 1'b1;
      step_rows[step_rows.size() - 1] = r;
    end
    foreach (step_rows[i]) scanlines_due.push_back(step_rows[i]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fg_reg       = 32'h00FF_FFFF;
      bg_reg       = 32'h0;
      width_reg    = 5'd8;
      height_reg   = 6'd16;
      count_reg    = 9'd256;
      cols_reg     = 8'd80;
      rows_reg     = 7'd30;
      col_pos      = '0;
      row_pos      = '0;
      mismatches   = 0;
      rows_seen    = 0;
      scrolls_seen = 0;
      scanlines_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_FG_COLOR:     fg_reg = cfg_wdata;
          CFG_BG_COLOR:     bg_reg = cfg_wdata;
          CFG_GLYPH_WIDTH:  width_reg = cfg_wdata[4:0];
          CFG_GLYPH_HEIGHT: height_reg = cfg_wdata[5:0];
          CFG_GLYPH_COUNT:  count_reg = cfg_wdata[8:0];
          CFG_TEXT_COLUMNS: cols_reg = cfg_wdata[7:0];
          CFG_TEXT_ROWS:    rows_reg = cfg_wdata[6:0];
          default: ;
        endcase
      end
      // Results are compared before the new item is predicted, so a result in
      // the same cycle can never match the item's own expectation.
      if (out_valid && out_ready) begin
        if (scanlines_due.size() == 0) begin
          $error("result with nothing expected: kind %0d x %0d y %0d bits 0x%0h",
                 out_item.kind, out_item.pixel_x, out_item.pixel_y, out_item.pixel_bits);
          mismatches++;
        end else begin
          want = scanlines_due.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_item.kind));
          check_field("pixel_x", 32'(want.pixel_x), 32'(out_item.pixel_x));
          check_field("pixel_y", 32'(want.pixel_y), 32'(out_item.pixel_y));
          check_field("pixel_bits", 32'(want.pixel_bits), 32'(out_item.pixel_bits));
          check_field("pixel_count", 32'(want.pixel_count), 32'(out_item.pixel_count));
          check_field("draw_fg", want.draw_fg, out_item.draw_fg);
          check_field("draw_bg", want.draw_bg, out_item.draw_bg);
          check_field("last", 32'(want.last), 32'(out_item.last));
          if (want.kind == KIND_SCROLL) scrolls_seen++;
          else rows_seen++;
        end
      end
      if (in_valid && in_ready) predict_console_step(in_item);
    end
    scanlines_outstanding = scanlines_due.size();
  end

endmodule

@@ bench/text_console_glyph_renderer_core_test.sv @@
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_core_test
// Stimulus and verdict for the text console renderer. The glyph store is
// filled first for every glyph a character can select, then a directed run
// covers control characters, glyph-0 codes and register clamps, and random
// phases follow, each under its own register setting, with random gaps on
// both channels. A separate checker predicts and compares all results.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core_test;
  import tcgr_pkg::*;

  localparam int         RANDOM_ITEMS  = 160;
  localparam int         SETTLE_CYCLES = 24;
  localparam int         TAIL_CYCLES   = 60;
  localparam int         STALL_LIMIT   = 1000;
  localparam logic [2:0] CFG_UNUSED    = 3'd7;

  logic      clk;
  logic      rst_n;
  logic      cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_wdata;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int mismatches;
  int scanlines_outstanding;
  int rows_seen;
  int scrolls_seen;

  int  items_sent;
  int  loads_sent;
  int  settings_used;
  int  idle_cycles;
  bit  steady;

  text_console_glyph_renderer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  glyph_scanline_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_item               (in_item),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_item              (out_item),
    .mismatches            (mismatches),
    .scanlines_outstanding (scanlines_outstanding),
    .rows_seen             (rows_seen),
    .scrolls_seen          (scrolls_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic in_item_t make_item(input logic cmd, input logic [7:0] code,
                                         input logic [4:0] frow, input logic [15:0] bits);
    in_item_t it;
    it.command   = cmd;
    it.char_code = code;
    it.font_row  = frow;
    it.row_bits  = bits;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = steady ? 0 : idle_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    if (it.command == CMD_LOAD) loads_sent++;
  endtask

  // Hold the sender off until every expected result has come, then give the
  // block time to finish any font loads still in its queue.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (scanlines_outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    logic [31:0] vals [8];
    logic [2:0]  idx  [8];
    vals[0] = c.fg_color;                       idx[0] = CFG_FG_COLOR;
    vals[1] = c.bg_color;                       idx[1] = CFG_BG_COLOR;
    vals[2] = {27'($urandom), c.glyph_width};   idx[2] = CFG_GLYPH_WIDTH;
    vals[3] = {26'($urandom), c.glyph_height};  idx[3] = CFG_GLYPH_HEIGHT;
    vals[4] = {23'($urandom), c.glyph_count};   idx[4] = CFG_GLYPH_COUNT;
    vals[5] = {24'($urandom), c.text_columns};  idx[5] = CFG_TEXT_COLUMNS;
    vals[6] = {25'($urandom), c.text_rows};     idx[6] = CFG_TEXT_ROWS;
    vals[7] = $urandom;                         idx[7] = CFG_UNUSED;
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic cfg_t pick_config(input int phase);
    cfg_t c;
    c.fg_color = $urandom;
    c.bg_color = $urandom;
    if (phase == 0) begin
      c.glyph_width  = 5'd1;
      c.glyph_height = 6'd1;
      c.glyph_count  = 9'd1;
      c.text_columns = 8'd1;
      c.text_rows    = 7'd1;
    end else if (phase == 1) begin
      c.glyph_width  = 5'd16;
      c.glyph_height = 6'd32;
      c.glyph_count  = 9'd256;
      c.text_columns = 8'd255;
      c.text_rows    = 7'd127;
    end else begin
      c.glyph_width  = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(1, 16))
                                                   : 5'($urandom_range(0, 31));
      c.glyph_height = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(1, 6))
                                                  : 6'($urandom_range(0, 63));
      c.glyph_count  = ($urandom_range(0, 4) < 3) ? 9'd256 : 9'($urandom_range(0, 511));
      c.text_columns = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 16))
                                                  : 8'($urandom_range(0, 255));
      c.text_rows    = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(1, 6))
                                                  : 7'($urandom_range(0, 127));
    end
    return c;
  endfunction

  // Mostly printable text with control characters mixed in, some font
  // rewrites, and a little fully random noise.
  function automatic in_item_t random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return make_item(CMD_PUT, 8'($urandom_range(32, 126)), '0, '0);
    if (r < 63) return make_item(CMD_PUT, CH_NL, '0, '0);
    if (r < 69) return make_item(CMD_PUT, CH_BS, '0, '0);
    if (r < 75) return make_item(CMD_PUT, CH_TAB, '0, '0);
    if (r < 79) return make_item(CMD_PUT, 8'($urandom_range(128, 255)), '0, '0);
    if (r < 83) return make_item(CMD_PUT, 8'($urandom_range(0, 127)), '0, '0);
    if (r < 93) return make_item(CMD_LOAD, 8'($urandom), 5'($urandom), 16'($urandom));
    return in_item_t'($urandom);
  endfunction

  // Receiver: stretches of steady readiness alternate with random stalls.
  initial begin
    out_ready = 1'b0;
    forever begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                          : $urandom_range(0, 10)) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
      repeat (idle_span()) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("text_console_glyph_renderer_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cfg_t c;
    int   phase;
    int   random_sent;
    int   n;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_item       = '0;
    idle_cycles   = 0;
    items_sent    = 0;
    loads_sent    = 0;
    settings_used = 0;
    steady        = 1'b1;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Every glyph a character can select gets all its rows written first.
    for (int g = 0; g < 128; g++) begin
      for (int y = 0; y < MAX_GLYPH_HEIGHT; y++) begin
        send_item(make_item(CMD_LOAD, 8'(g), 5'(y), 16'($urandom)));
      end
    end
    steady = 1'b0;

    // Directed part under the reset register values.
    send_item(make_item(CMD_LOAD, 8'd65, 5'd0, 16'hFFFF));
    send_item(make_item(CMD_LOAD, 8'd65, 5'd1, 16'h0000));
    send_item(make_item(CMD_LOAD, 8'd255, 5'd31, 16'($urandom)));
    send_item(make_item(CMD_PUT, 8'd65, '0, '0));
    send_item(make_item(CMD_PUT, 8'd0, '0, '0));
    send_item(make_item(CMD_PUT, 8'd128, '0, '0));
    send_item(make_item(CMD_PUT, 8'd255, '0, '0));
    send_item(make_item(CMD_PUT, 8'd127, '0, '0));
    send_item(make_item(CMD_PUT, CH_TAB, '0, '0));
    send_item(make_item(CMD_PUT, CH_BS, '0, '0));
    send_item(make_item(CMD_PUT, CH_NL, '0, '0));
    send_item(make_item(CMD_PUT, CH_BS, '0, '0));
    send_item(make_item(CMD_PUT, CH_TAB, '0, '0));
    send_item(make_item(CMD_PUT, CH_TAB, '0, '0));

    // Register values below the legal range are clamped up.
    wait_idle();
    c = '{fg_color: 32'hFFFF_FFFF, bg_color: 32'h0, glyph_width: 5'd0, glyph_height: 6'd0,
          glyph_count: 9'd0, text_columns: 8'd0, text_rows: 7'd0};
    apply_config(c);
    send_item(make_item(CMD_PUT, 8'd66, '0, '0));
    send_item(make_item(CMD_PUT, CH_NL, '0, '0));
    send_item(make_item(CMD_PUT, 8'd5, '0, '0));
    send_item(make_item(CMD_PUT, CH_BS, '0, '0));

    // And values above it are clamped down.
    wait_idle();
    c = '{fg_color: 32'h0, bg_color: 32'hFFFF_FFFF, glyph_width: 5'd31, glyph_height: 6'd63,
          glyph_count: 9'd511, text_columns: 8'd255, text_rows: 7'd127};
    apply_config(c);
    send_item(make_item(CMD_PUT, 8'd127, '0, '0));
    send_item(make_item(CMD_PUT, 8'd65, '0, '0));
    send_item(make_item(CMD_PUT, CH_TAB, '0, '0));
    send_item(make_item(CMD_PUT, CH_SPACE, '0, '0));

    // Random phases, each under a fresh register setting. The cursor carries
    // over, so a shrinking screen leaves it beyond the new limits.
    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      apply_config(pick_config(phase));
      steady = ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        // Tab far enough right that the pixel column runs past 12 bits.
        n = $urandom_range(60, 63);
        repeat (n) send_item(make_item(CMD_PUT, CH_TAB, '0, '0));
        random_sent += n;
      end
      n = $urandom_range(12, 28);
      repeat (n) send_item(random_item());
      random_sent += n;
      phase++;
    end

    in_valid <= 1'b0;
    while (scanlines_outstanding != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d items (%0d font row loads) under %0d register settings;",
             items_sent, loads_sent, settings_used);
    $display("checked %0d scanline results and %0d scrolls.", rows_seen, scrolls_seen);
    if (mismatches == 0) begin
      $display("text_console_glyph_renderer_core: match");
    end else begin
      $display("text_console_glyph_renderer_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/tcgr_pkg.sv
sv/tcgr_ram.sv
sv/tcgr_front.sv
sv/tcgr_fifo.sv
sv/tcgr_back.sv
sv/text_console_glyph_renderer_core.sv
bench/glyph_scanline_checker.sv
bench/text_console_glyph_renderer_core_test.sv
